// File: src/nca_pkg.sv
package nca_pkg;

    localparam int ACC_BITS     = 38;
    localparam int SQ_MAG_BITS  = ACC_BITS / 2;
    localparam int CFG_W        = 5;
    localparam int CFG_ADDR_W   = 1;
    localparam int CIDX_W       = 4;
    localparam int DIDX_W       = 4;
    localparam int ID_W         = 5;
    localparam int OUT_TDATA_W  = 8;

    localparam logic [ACC_BITS-1:0] ACC_MAX = {ACC_BITS{1'b1}};

    localparam logic [CFG_ADDR_W-1:0] CFG_NUM_CLUSTERS = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_NUM_DIMS     = 1'b1;

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_POINT = 1'b1
    } t_action;

endpackage

// File: src/nca_ram.sv
module nca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/nearest_centroid_assign.sv
// Load beats, and point beats that add nothing and do not end a point, are taken while the block stays idle.
// Any other point beat sweeps the k active clusters through one centroid store read port and a
// three-stage difference, square and accumulate pipeline; no new beat is taken until it is done.
// A last coordinate waits in the final step while an earlier result is still held at the output.
// Synchronous active-low reset sets both counts to 1, empties the output and zeroes the distances.
module nearest_centroid_assign #(
    parameter int MAX_CLUSTERS = 16,
    parameter int MAX_DIMS     = 16,
    parameter int COORD_BITS   = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [nca_pkg::CFG_ADDR_W-1:0]         i_cfg_addr,
    input  logic [nca_pkg::CFG_W-1:0]              i_cfg_data,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // cluster_index [3:0], dim_index [7:4], coord_value [8 +: COORD_BITS], zero padding
    input  logic [((nca_pkg::CIDX_W + nca_pkg::DIDX_W + COORD_BITS + 7) / 8) * 8 - 1:0] i_s_tdata,
    // action
    input  logic                                   i_s_tuser,
    input  logic                                   i_s_tlast,
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // nearest centroid id [4:0], zero padding
    output logic [nca_pkg::OUT_TDATA_W-1:0]        o_m_tdata
);

    import nca_pkg::*;

    localparam int CI_W     = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int K_W      = $clog2(MAX_CLUSTERS + 1);
    localparam int DM_W     = $clog2(MAX_DIMS + 1);
    localparam int ST_DEPTH = MAX_CLUSTERS * MAX_DIMS;
    localparam int ST_AW    = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;
    localparam int DIFF_W   = COORD_BITS + 1;
    localparam int MAG_W    = (DIFF_W > SQ_MAG_BITS + 1) ? DIFF_W : SQ_MAG_BITS + 1;
    localparam int COORD_LO = CIDX_W + DIDX_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } t_state;

    t_state r_state;

    logic [CFG_W-1:0]          r_num_clusters;
    logic [CFG_W-1:0]          r_num_dims;
    logic [K_W-1:0]            k_cnt;
    logic [DM_W-1:0]           dims_cnt;
    logic [CI_W-1:0]           k_last;

    logic [CIDX_W-1:0]         in_cidx;
    logic [DIDX_W-1:0]         in_didx;
    logic [COORD_BITS-1:0]     in_coord;
    t_action                   in_act;
    logic                      accept;
    logic                      in_range;
    logic                      pt_start;

    logic                      st_we;
    logic [ST_AW-1:0]          st_waddr;
    logic [COORD_BITS-1:0]     st_rdata;

    logic [COORD_BITS-1:0]     r_coord;
    logic                      r_add_en;
    logic                      r_last;
    logic [ST_AW-1:0]          r_raddr;
    logic                      r_issue;
    logic [CI_W-1:0]           r_idx;

    logic                      r_v1, r_v2, r_v3;
    logic [CI_W-1:0]           r_i1, r_i2, r_i3;

    logic signed [DIFF_W-1:0]  diff;
    logic [MAG_W-1:0]          mag_ext;
    logic [SQ_MAG_BITS-1:0]    r_mag;
    logic                      r_sat;
    logic [2*SQ_MAG_BITS-1:0]  sq_prod;
    logic [ACC_BITS-1:0]       r_sq;

    logic [ACC_BITS-1:0]       acc_rdata;
    logic [ACC_BITS-1:0]       acc_cur;
    logic [ACC_BITS:0]         acc_sum;
    logic [ACC_BITS-1:0]       acc_new;
    logic [MAX_CLUSTERS-1:0]   r_acc_valid;

    logic [ACC_BITS-1:0]       r_best_dist;
    logic [CI_W-1:0]           r_best_idx;
    logic                      r_out_valid;
    logic [ID_W-1:0]           r_out_id;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_clusters <= CFG_W'(1);
            r_num_dims     <= CFG_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_NUM_CLUSTERS: r_num_clusters <= i_cfg_data;
                CFG_NUM_DIMS:     r_num_dims     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Counts out of range saturate into 1..MAX.
    always_comb begin
        if (r_num_clusters == '0) begin
            k_cnt = K_W'(1);
        end else if (int'(r_num_clusters) > MAX_CLUSTERS) begin
            k_cnt = K_W'(MAX_CLUSTERS);
        end else begin
            k_cnt = K_W'(r_num_clusters);
        end
        if (r_num_dims == '0) begin
            dims_cnt = DM_W'(1);
        end else if (int'(r_num_dims) > MAX_DIMS) begin
            dims_cnt = DM_W'(MAX_DIMS);
        end else begin
            dims_cnt = DM_W'(r_num_dims);
        end
    end

    assign k_last = CI_W'(k_cnt - K_W'(1));

    assign in_cidx  = i_s_tdata[CIDX_W-1:0];
    assign in_didx  = i_s_tdata[CIDX_W +: DIDX_W];
    assign in_coord = i_s_tdata[COORD_LO +: COORD_BITS];
    assign in_act   = t_action'(i_s_tuser);

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign in_range   = (int'(in_didx) < int'(dims_cnt));
    assign pt_start   = accept && (in_act == ACT_POINT) && (in_range || i_s_tlast);

    assign st_we    = accept && (in_act == ACT_LOAD) && (int'(in_cidx) < MAX_CLUSTERS)
                      && (int'(in_didx) < MAX_DIMS);
    assign st_waddr = ST_AW'(int'(in_cidx) * MAX_DIMS) + ST_AW'(in_didx);

    nca_ram #(
        .WIDTH (COORD_BITS),
        .DEPTH (ST_DEPTH)
    ) u_centroid_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (in_coord),
        .i_raddr (r_raddr),
        .o_rdata (st_rdata)
    );

    // Stage 1: centroid word is on the read port; take the magnitude of the difference.
    always_comb begin
        diff    = DIFF_W'($signed(st_rdata)) - DIFF_W'($signed(r_coord));
        mag_ext = MAG_W'(diff[DIFF_W-1] ? -diff : diff);
    end

    // Stage 2: square.
    assign sq_prod = r_mag * r_mag;

    // Stage 3: accumulator word is on its read port; add with saturation.
    always_comb begin
        acc_cur = r_acc_valid[r_i3] ? acc_rdata : '0;
        acc_sum = {1'b0, acc_cur} + {1'b0, (r_add_en ? r_sq : ACC_BITS'(0))};
        acc_new = acc_sum[ACC_BITS] ? ACC_MAX : acc_sum[ACC_BITS-1:0];
    end

    nca_ram #(
        .WIDTH (ACC_BITS),
        .DEPTH (MAX_CLUSTERS)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (r_v3),
        .i_waddr (r_i3),
        .i_wdata (acc_new),
        .i_raddr (r_i2),
        .o_rdata (acc_rdata)
    );

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (pt_start) begin
            r_coord  <= in_coord;
            r_add_en <= in_range;
            r_last   <= i_s_tlast;
            r_raddr  <= ST_AW'(in_didx);
        end else if (r_issue) begin
            r_raddr  <= r_raddr + ST_AW'(MAX_DIMS);
        end
        r_i1  <= r_idx;
        r_i2  <= r_i1;
        r_i3  <= r_i2;
        r_mag <= mag_ext[SQ_MAG_BITS-1:0];
        r_sat <= |mag_ext[MAG_W-1:SQ_MAG_BITS];
        r_sq  <= r_sat ? ACC_MAX : sq_prod;
        if (r_v3 && ((r_i3 == '0) || (acc_new < r_best_dist))) begin
            r_best_dist <= acc_new;
            r_best_idx  <= r_i3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= r_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issue     <= 1'b0;
            r_idx       <= '0;
            r_acc_valid <= '0;
            r_out_valid <= 1'b0;
            r_out_id    <= '0;
        end else begin
            if (r_out_valid && i_m_tready && !((r_state == ST_FINISH) && r_last)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (pt_start) begin
                        r_state <= ST_SWEEP;
                        r_issue <= 1'b1;
                        r_idx   <= '0;
                    end
                end
                ST_SWEEP: begin
                    if (r_issue) begin
                        if (r_idx == k_last) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_idx <= r_idx + CI_W'(1);
                        end
                    end
                    if (r_v3) begin
                        r_acc_valid[r_i3] <= 1'b1;
                        if (r_i3 == k_last) begin
                            r_state <= ST_FINISH;
                        end
                    end
                end
                ST_FINISH: begin
                    if (!r_last) begin
                        r_state <= ST_IDLE;
                    end else if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_id    <= ID_W'(r_best_idx) + ID_W'(1);
                        r_acc_valid <= '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W - ID_W){1'b0}}, r_out_id};

endmodule

// File: src/nca_checker.sv
module nca_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_s_tvalid,
    input logic                                   o_s_tready,
    input logic                                   i_s_tuser,
    input logic                                   i_s_tlast,
    input logic                                   o_m_tvalid,
    input logic                                   i_m_tready,
    input logic [nca_pkg::OUT_TDATA_W-1:0]        o_m_tdata
);

    import nca_pkg::*;

    logic in_beat;

    assign in_beat = i_s_tvalid && o_s_tready;

    // The output register comes out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_m_tvalid)
        else $error("result valid right after reset");

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // A load beat never produces a result.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && (i_s_tuser == ACT_LOAD) && !o_m_tvalid |=> !o_m_tvalid)
        else $error("result after a load beat");

    // The last coordinate of a point starts a sweep, so input is held off.
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && (i_s_tuser == ACT_POINT) && i_s_tlast |=> !o_s_tready)
        else $error("input taken during the cluster sweep");

endmodule

bind nearest_centroid_assign nca_checker u_nca_checker (.*);

// File: tb/nearest_centroid_assign_tb.sv
module nearest_centroid_assign_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nca_pkg::*;

    localparam int NUM_SLOTS   = 16;
    localparam int COORD_W     = 16;
    localparam int S_TDATA_W   = ((CIDX_W + DIDX_W + COORD_W + 7) / 8) * 8;
    localparam int SETTLE      = 32;
    localparam int RANDOM_BEATS = 500;
    localparam logic [COORD_W-1:0] COORD_MIN = 16'h8000;
    localparam logic [COORD_W-1:0] COORD_MAX = 16'h7FFF;
    localparam longint unsigned ACC_LIMIT = ACC_MAX;

    typedef enum logic {
        ROW_REG,
        ROW_BEAT
    } t_row_kind;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_BLOCKS
    } t_rx_mode;

    typedef struct {
        t_action            act;
        logic [CIDX_W-1:0]  cidx;
        logic [DIDX_W-1:0]  didx;
        logic signed [15:0] coord;
        logic               last;
    } t_beat;

    typedef struct {
        t_row_kind             kind;
        t_beat                 beat;
        logic [CFG_ADDR_W-1:0] reg_addr;
        logic [CFG_W-1:0]      reg_value;
        int                    typed_id;
    } t_script_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // cluster_index [3:0], dim_index [7:4], coord_value [23:8]
    logic [S_TDATA_W-1:0]   i_s_tdata = '0;
    // action
    logic                   i_s_tuser = 1'b0;
    logic                   i_s_tlast = 1'b0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // nearest centroid id [4:0], zero padding
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    nearest_centroid_assign i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state.
    logic signed [15:0] centroid_mem [NUM_SLOTS][NUM_SLOTS];
    bit                 centroid_loaded [NUM_SLOTS][NUM_SLOTS];
    longint unsigned    dist_acc [NUM_SLOTS];
    logic [CFG_W-1:0]   cluster_count_reg = 5'd1;
    logic [CFG_W-1:0]   dim_count_reg = 5'd1;

    logic [ID_W-1:0]    pending_ids [$];
    t_script_row        script_rows [$];

    int mismatch_count = 0;
    int results_checked = 0;
    int beats_sent = 0;
    int settings_run = 0;
    int burst_left = 0;
    int min_k = NUM_SLOTS, max_k = 0, min_dims = NUM_SLOTS, max_dims = 0;

    function automatic int clamp_count(input logic [CFG_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > NUM_SLOTS)
            return NUM_SLOTS;
        return int'(raw);
    endfunction

    // Applies one accepted beat to the model state; a point's last coordinate
    // yields the 1-based id of the nearest active centroid.
    task automatic nearest_cluster_step(input t_beat b, output bit emits,
                                        output logic [ID_W-1:0] nearest);
        int k, dims, diff, best;
        longint unsigned mag, sq, total, best_dist;
        emits = 1'b0;
        nearest = '0;
        k = clamp_count(cluster_count_reg);
        dims = clamp_count(dim_count_reg);
        if (b.act == ACT_LOAD) begin
            centroid_mem[b.cidx][b.didx] = b.coord;
            centroid_loaded[b.cidx][b.didx] = 1'b1;
            return;
        end
        if (int'(b.didx) < dims) begin
            for (int i = 0; i < k; i++) begin
                diff = int'(centroid_mem[i][b.didx]) - int'(b.coord);
                mag = (diff < 0) ? longint'(-diff) : longint'(diff);
                sq = (mag >= (64'd1 << SQ_MAG_BITS)) ? ACC_LIMIT : mag * mag;
                total = dist_acc[i] + sq;
                dist_acc[i] = (total > ACC_LIMIT) ? ACC_LIMIT : total;
            end
        end
        if (!b.last)
            return;
        best = 0;
        best_dist = dist_acc[0];
        for (int i = 1; i < k; i++) begin
            if (dist_acc[i] < best_dist) begin
                best_dist = dist_acc[i];
                best = i;
            end
        end
        foreach (dist_acc[i])
            dist_acc[i] = 0;
        emits = 1'b1;
        nearest = ID_W'(best + 1);
    endtask

    // Called at a rising edge; returns at the edge where the beat is taken.
    // A nonzero typed_id replaces the predicted id for that beat.
    task automatic put_beat(input t_action act, input logic [3:0] cidx,
                            input logic [3:0] didx, input logic [15:0] coord,
                            input logic last, input int typed_id = 0);
        t_beat b;
        bit emits;
        logic [ID_W-1:0] nearest;
        int idle;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (idle > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (idle) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tlast  <= last;
        i_s_tdata  <= {coord, didx, cidx};
        do
            @(posedge i_clk);
        while (!o_s_tready);
        beats_sent++;
        b.act = act;
        b.cidx = cidx;
        b.didx = didx;
        b.coord = coord;
        b.last = last;
        nearest_cluster_step(b, emits, nearest);
        if (emits)
            pending_ids = {pending_ids, ((typed_id != 0) ? ID_W'(typed_id) : nearest)};
    endtask

    // Holds the input side idle until every id has come back and the
    // pipeline has had time to finish a beat that produces nothing.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_ids.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == CFG_NUM_CLUSTERS)
            cluster_count_reg = value;
        else
            dim_count_reg = value;
        @(posedge i_clk);
    endtask

    function automatic void row_beat(input t_action act, input logic [3:0] cidx,
                                     input logic [3:0] didx, input logic [15:0] coord,
                                     input logic last, input int typed_id = 0);
        t_script_row r;
        r.kind = ROW_BEAT;
        r.beat.act = act;
        r.beat.cidx = cidx;
        r.beat.didx = didx;
        r.beat.coord = coord;
        r.beat.last = last;
        r.reg_addr = '0;
        r.reg_value = '0;
        r.typed_id = typed_id;
        script_rows = {script_rows, r};
    endfunction

    function automatic void row_reg(input logic [CFG_ADDR_W-1:0] addr,
                                    input logic [CFG_W-1:0] value);
        t_script_row r;
        r.kind = ROW_REG;
        r.beat.act = ACT_LOAD;
        r.beat.cidx = '0;
        r.beat.didx = '0;
        r.beat.coord = '0;
        r.beat.last = 1'b0;
        r.reg_addr = addr;
        r.reg_value = value;
        r.typed_id = 0;
        script_rows = {script_rows, r};
    endfunction

    function automatic logic [CFG_W-1:0] pick_count_raw();
        case ($urandom_range(0, 9))
            0: return 5'd0;
            1: return 5'd16;
            2: return CFG_W'($urandom_range(17, 31));
            default: return CFG_W'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [15:0] centroid_value(input int style);
        case (style)
            0: return 16'($urandom());
            // A few spaced values, so that equal distances are common.
            1: return 16'(int'($urandom_range(0, 3)) * 256 - 512);
            2: begin
                case ($urandom_range(0, 3))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return 16'hFFFF;
                    default: return 16'h0000;
                endcase
            end
            default: return 16'(int'($urandom_range(0, 4095)) - 2048);
        endcase
    endfunction

    // One point, mostly near a chosen centroid; some points are cut short,
    // repeat a coordinate or carry stray beats.
    task automatic send_point(input int k, input int dims, input int style);
        int order [$];
        int target, j, pick, tmp, v, d;
        target = $urandom_range(0, k - 1);
        for (d = 0; d < dims; d++)
            order = {order, d};
        if ($urandom_range(0, 2) == 0) begin
            for (j = order.size() - 1; j > 0; j--) begin
                pick = $urandom_range(0, j);
                tmp = order[j];
                order[j] = order[pick];
                order[pick] = tmp;
            end
        end
        case ($urandom_range(0, 9))
            0: if (order.size() > 1) void'(order.pop_back());
            1: order = {order, order[$urandom_range(0, order.size() - 1)]};
            default: ;
        endcase
        for (j = 0; j < order.size(); j++) begin
            if (dims < NUM_SLOTS && $urandom_range(0, 9) == 0)
                put_beat(ACT_POINT, 4'($urandom()), 4'($urandom_range(dims, 15)),
                         16'($urandom()), 1'b0);
            if ($urandom_range(0, 19) == 0)
                put_beat(ACT_LOAD, 4'($urandom_range(0, k - 1)), 4'(order[j]),
                         centroid_value(style), 1'($urandom()));
            d = order[j];
            case ($urandom_range(0, 9))
                0, 1: v = int'($urandom_range(0, 65535)) - 32768;
                2: v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
                default: begin
                    v = int'(centroid_mem[target][d]) + int'($urandom_range(0, 600)) - 300;
                    if (v > 32767)
                        v = 32767;
                    if (v < -32768)
                        v = -32768;
                end
            endcase
            put_beat(ACT_POINT, 4'($urandom()), 4'(d), v[15:0], j == order.size() - 1);
        end
    endtask

    task automatic run_setting();
        logic [CFG_W-1:0] k_raw, d_raw;
        int k, dims, style, points;
        k_raw = pick_count_raw();
        d_raw = pick_count_raw();
        write_reg(CFG_NUM_CLUSTERS, k_raw);
        write_reg(CFG_NUM_DIMS, d_raw);
        settings_run++;
        k = clamp_count(k_raw);
        dims = clamp_count(d_raw);
        if (k < min_k) min_k = k;
        if (k > max_k) max_k = k;
        if (dims < min_dims) min_dims = dims;
        if (dims > max_dims) max_dims = dims;
        style = $urandom_range(0, 3);
        // Every entry a point can read is loaded before the first point.
        for (int c = 0; c < k; c++) begin
            for (int d = 0; d < dims; d++) begin
                if (!centroid_loaded[c][d] || $urandom_range(0, 2) == 0)
                    put_beat(ACT_LOAD, 4'(c), 4'(d), centroid_value(style), 1'($urandom()));
            end
        end
        points = $urandom_range(2, 8);
        for (int p = 0; p < points; p++)
            send_point(k, dims, style);
        if (dims < NUM_SLOTS && $urandom_range(0, 3) == 0)
            put_beat(ACT_POINT, 4'($urandom()), 4'($urandom_range(dims, 15)),
                     16'($urandom()), 1'b1);
        if ($urandom_range(0, 2) == 0)
            put_beat(ACT_LOAD, 4'($urandom()), 4'($urandom()), 16'($urandom()),
                     1'($urandom()));
        wait_drained();
    endtask

    // Receiver: ready follows a randomly chosen mode that changes now and then.
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_mode_left = 0;
    int       rx_hold_left = 0;
    logic     rx_hold_level = 1'b0;

    always @(posedge i_clk) begin
        logic ready;
        if (rx_mode_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(16, 160);
        end
        rx_mode_left--;
        case (rx_mode)
            RX_OPEN: ready = 1'b1;
            RX_COIN: ready = 1'($urandom());
            RX_SPARSE: ready = ($urandom_range(0, 3) == 0);
            default: begin
                if (rx_hold_left == 0) begin
                    rx_hold_left = $urandom_range(1, 12);
                    rx_hold_level = ~rx_hold_level;
                end
                rx_hold_left--;
                ready = rx_hold_level;
            end
        endcase
        i_m_tready <= ready;
    end

    always @(posedge i_clk) begin
        logic [ID_W-1:0] want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_ids.size() == 0) begin
                $display("%0t: result beat with none expected: id %0d",
                         $time, o_m_tdata[ID_W-1:0]);
                mismatch_count++;
            end else begin
                want = pending_ids.pop_front();
                results_checked++;
                if (o_m_tdata[ID_W-1:0] !== want) begin
                    $display("%0t: nearest id mismatch: expected %0d, actual %0d",
                             $time, want, o_m_tdata[ID_W-1:0]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #(4_000_000);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int script_beats;
        foreach (centroid_mem[c, d]) begin
            centroid_mem[c][d] = '0;
            centroid_loaded[c][d] = 1'b0;
        end
        foreach (dist_acc[i])
            dist_acc[i] = 0;

        // After reset a single cluster is active, so every point maps to id 1.
        row_beat(ACT_LOAD, 4'd0, 4'd0, 16'h0000, 1'b0);
        row_beat(ACT_POINT, 4'd0, 4'd0, COORD_MAX, 1'b1, 1);
        // A count of zero acts as one; a last mark on a load produces nothing.
        row_reg(CFG_NUM_CLUSTERS, 5'd0);
        row_beat(ACT_LOAD, 4'd0, 4'd0, COORD_MIN, 1'b1);
        row_beat(ACT_POINT, 4'd0, 4'd0, COORD_MIN, 1'b1, 1);
        row_reg(CFG_NUM_CLUSTERS, 5'd3);
        row_reg(CFG_NUM_DIMS, 5'd2);
        row_beat(ACT_LOAD, 4'd0, 4'd0, COORD_MIN, 1'b0);
        row_beat(ACT_LOAD, 4'd0, 4'd1, COORD_MIN, 1'b0);
        row_beat(ACT_LOAD, 4'd1, 4'd0, 16'h0000, 1'b0);
        row_beat(ACT_LOAD, 4'd1, 4'd1, 16'h0000, 1'b0);
        row_beat(ACT_LOAD, 4'd2, 4'd0, 16'h0000, 1'b0);
        row_beat(ACT_LOAD, 4'd2, 4'd1, 16'h0000, 1'b0);
        row_beat(ACT_LOAD, 4'd15, 4'd15, COORD_MAX, 1'b1);
        // Clusters 1 and 2 tie at zero distance; the lower index wins.
        row_beat(ACT_POINT, 4'd0, 4'd0, 16'h0000, 1'b0);
        row_beat(ACT_POINT, 4'd0, 4'd1, 16'h0000, 1'b1, 2);
        row_beat(ACT_POINT, 4'd15, 4'd1, COORD_MIN, 1'b0);
        row_beat(ACT_POINT, 4'd15, 4'd0, COORD_MIN, 1'b1, 1);
        // A coordinate beyond the point size adds nothing but still ends it.
        row_beat(ACT_POINT, 4'd0, 4'd5, 16'h0005, 1'b1, 1);
        row_beat(ACT_POINT, 4'd0, 4'd0, COORD_MAX, 1'b0);
        row_beat(ACT_POINT, 4'd0, 4'd15, 16'hFFFF, 1'b1, 2);
        row_beat(ACT_LOAD, 4'd2, 4'd0, 16'h00C8, 1'b0);
        row_beat(ACT_POINT, 4'd7, 4'd0, 16'h0096, 1'b0);
        row_beat(ACT_POINT, 4'd8, 4'd1, 16'hFFF9, 1'b1);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script_rows[r]) begin
            if (script_rows[r].kind == ROW_REG) begin
                wait_drained();
                write_reg(script_rows[r].reg_addr, script_rows[r].reg_value);
            end else begin
                put_beat(script_rows[r].beat.act, script_rows[r].beat.cidx,
                         script_rows[r].beat.didx, script_rows[r].beat.coord,
                         script_rows[r].beat.last, script_rows[r].typed_id);
            end
        end
        script_beats = beats_sent;
        wait_drained();

        while (beats_sent < script_beats + RANDOM_BEATS)
            run_setting();
        wait_drained();

        $display("Sent %0d beats and checked %0d cluster ids over %0d register settings.",
                 beats_sent, results_checked, settings_run);
        $display("Active clusters ranged %0d..%0d and point sizes %0d..%0d.",
                 min_k, max_k, min_dims, max_dims);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
